FILE: design/dvf_pkg.sv
// ============================================================================
// DXTC vertical flip remapper - shared package
// Types, codes and block permutation functions shared by the flip remapper.
// ============================================================================
package dvf_pkg;

    // Block format codes, as held in the format register.
    localparam logic [1:0] FMT_DXT1 = 2'd0;
    localparam logic [1:0] FMT_DXT3 = 2'd1;
    localparam logic [1:0] FMT_DXT5 = 2'd2;
    localparam logic [1:0] FMT_NONE = 2'd3;

    // Configuration register indexes.
    localparam int unsigned CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_FORMAT = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_LEVEL_COUNT  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_TOTAL_BLOCKS = 3'd4;
    localparam int unsigned CFG_DATA_W = 25;

    // Field widths.
    localparam int unsigned DIM_W   = 15;
    localparam int unsigned LEVEL_W = 4;
    localparam int unsigned BLOCK_W = 25;
    localparam int unsigned POS_W   = 12;

    // Largest legal dimension and level count; block positions wrap at 2^BLOCK_W.
    localparam logic [DIM_W-1:0]   MAX_DIM    = 15'd16384;
    localparam logic [LEVEL_W-1:0] MAX_LEVELS = 4'd15;

    // Depth of the queue between the front and back ends.
    localparam int unsigned QUEUE_DEPTH = 2;

    // How a block is treated.
    typedef enum logic [1:0] {
        MODE_PASS = 2'd0,
        MODE_HALF = 2'd1,
        MODE_FULL = 2'd2
    } t_flip_mode;

    // Good level counter states.
    typedef enum logic [1:0] {
        CNT_IDLE  = 2'd0,
        CNT_CHECK = 2'd1,
        CNT_MUL   = 2'd2,
        CNT_TEST  = 2'd3
    } t_cnt_state;

    typedef struct packed {
        logic [63:0] block_low;
        logic [63:0] block_high;
    } t_in_item;

    typedef struct packed {
        logic [63:0]        flipped_low;
        logic [63:0]        flipped_high;
        logic [BLOCK_W-1:0] dest_index;
        logic               was_changed;
        logic [LEVEL_W-1:0] good_levels;
    } t_out_item;

    // Status of the good level counter, seen by the front end.
    typedef struct packed {
        logic               busy;
        logic [LEVEL_W-1:0] good_levels;
    } t_count_status;

    // One classified block, waiting for the back end.
    typedef struct packed {
        t_flip_mode         mode;
        logic [1:0]         fmt;
        logic [63:0]        lo;
        logic [63:0]        hi;
        logic               changed;
        logic [LEVEL_W-1:0] good_levels;
        logic [BLOCK_W-1:0] stream_pos;
        logic [BLOCK_W-1:0] level_base;
        logic [POS_W-1:0]   row_rev;
        logic [POS_W:0]     blocks_per_row;
        logic [POS_W-1:0]   column;
    } t_work;

    typedef struct packed {
        logic [63:0] lo;
        logic [63:0] hi;
    } t_block_pair;

    // Color half: reverse the four row bytes.
    function automatic logic [63:0] colour_full(input logic [63:0] x);
        return {x[39:32], x[47:40], x[55:48], x[63:56], x[31:0]};
    endfunction

    // Color half: swap rows 0 and 1 only.
    function automatic logic [63:0] colour_half(input logic [63:0] x);
        return {x[63:48], x[39:32], x[47:40], x[31:0]};
    endfunction

    // Explicit alpha: reverse the four 16-bit rows.
    function automatic logic [63:0] alpha4_full(input logic [63:0] x);
        return {x[15:0], x[31:16], x[47:32], x[63:48]};
    endfunction

    function automatic logic [63:0] alpha4_half(input logic [63:0] x);
        return {x[63:32], x[15:0], x[31:16]};
    endfunction

    // Interpolated alpha: 12-bit rows packed in two 24-bit pairs.
    function automatic logic [63:0] alpha3_full(input logic [63:0] x);
        return {x[27:16], x[39:28], x[51:40], x[63:52], x[15:0]};
    endfunction

    function automatic logic [63:0] alpha3_half(input logic [63:0] x);
        return {x[63:40], x[27:16], x[39:28], x[15:0]};
    endfunction

    // Apply the flip that the mode and format call for.
    function automatic t_block_pair flip_block(input t_flip_mode mode, input logic [1:0] fmt,
                                               input logic [63:0] lo, input logic [63:0] hi);
        t_block_pair res;
        res.lo = lo;
        res.hi = hi;
        case (mode)
            MODE_HALF: begin
                case (fmt)
                    FMT_DXT1: res.lo = colour_half(lo);
                    FMT_DXT3: begin
                        res.lo = alpha4_half(lo);
                        res.hi = colour_half(hi);
                    end
                    FMT_DXT5: begin
                        res.lo = alpha3_half(lo);
                        res.hi = colour_half(hi);
                    end
                    default: ;
                endcase
            end
            MODE_FULL: begin
                case (fmt)
                    FMT_DXT1: res.lo = colour_full(lo);
                    FMT_DXT3: begin
                        res.lo = alpha4_full(lo);
                        res.hi = colour_full(hi);
                    end
                    FMT_DXT5: begin
                        res.lo = alpha3_full(lo);
                        res.hi = colour_full(hi);
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
        return res;
    endfunction

endpackage

FILE: design/dvf_level_counter.sv
// ============================================================================
// DXTC vertical flip remapper - good level counter
// Walks the mip chain once per restart, one level per pass through the multiply
// and test states, and finds how many levels fit in the blocks present.
// ============================================================================
module dvf_level_counter (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [1:0]                  i_block_format,
    input  logic [dvf_pkg::DIM_W-1:0]   i_image_width,
    input  logic [dvf_pkg::DIM_W-1:0]   i_image_height,
    input  logic [dvf_pkg::LEVEL_W-1:0] i_level_count,
    input  logic [dvf_pkg::BLOCK_W-1:0] i_total_blocks,
    output dvf_pkg::t_count_status      o_status
);

    dvf_pkg::t_cnt_state r_state, n_state;
    logic [dvf_pkg::DIM_W-1:0]   r_w, n_w, r_h, n_h;
    logic [dvf_pkg::BLOCK_W-1:0] r_used, n_used;
    logic [25:0]                 r_blocks, n_blocks;
    logic [dvf_pkg::LEVEL_W-1:0] r_lvl, n_lvl, r_levels, n_levels, r_result, n_result;

    logic        w_bad;
    logic [15:0] w_wsum, w_hsum;
    logic [26:0] w_total_used;
    logic        w_over;

    // Configurations that give no good level at all.
    always_comb begin
        w_bad = (i_block_format == dvf_pkg::FMT_NONE)
             || (i_image_width == '0) || (i_image_height == '0)
             || ((i_image_height & (i_image_height - 15'd1)) != '0)
             || (i_image_width > dvf_pkg::MAX_DIM)
             || (i_image_height > dvf_pkg::MAX_DIM);
    end

    // Blocks of the current level, and whether they still fit.
    assign w_wsum       = {1'b0, r_w} + 16'd3;
    assign w_hsum       = {1'b0, r_h} + 16'd3;
    assign w_total_used = {2'b0, r_used} + {1'b0, r_blocks};
    assign w_over       = w_total_used > {2'b0, i_total_blocks};

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            dvf_pkg::CNT_IDLE:  n_state = dvf_pkg::CNT_IDLE;
            dvf_pkg::CNT_CHECK: n_state = w_bad ? dvf_pkg::CNT_IDLE : dvf_pkg::CNT_MUL;
            dvf_pkg::CNT_MUL: begin
                n_state = (r_lvl == r_levels) ? dvf_pkg::CNT_IDLE : dvf_pkg::CNT_TEST;
            end
            dvf_pkg::CNT_TEST: begin
                n_state = (w_over || r_h == 15'd1) ? dvf_pkg::CNT_IDLE : dvf_pkg::CNT_MUL;
            end
            default: n_state = dvf_pkg::CNT_IDLE;
        endcase
        if (i_start) begin
            n_state = dvf_pkg::CNT_CHECK;
        end
    end

    // Walk registers.
    always_comb begin
        n_w      = r_w;
        n_h      = r_h;
        n_used   = r_used;
        n_blocks = r_blocks;
        n_lvl    = r_lvl;
        n_levels = r_levels;
        n_result = r_result;
        case (r_state)
            dvf_pkg::CNT_CHECK: begin
                n_w      = i_image_width;
                n_h      = i_image_height;
                n_used   = '0;
                n_lvl    = '0;
                n_levels = (i_level_count > dvf_pkg::MAX_LEVELS) ? dvf_pkg::MAX_LEVELS
                                                                  : i_level_count;
                if (w_bad) begin
                    n_result = '0;
                end
            end
            dvf_pkg::CNT_MUL: begin
                n_blocks = w_wsum[14:2] * w_hsum[14:2];
                if (r_lvl == r_levels) begin
                    n_result = r_levels;
                end
            end
            dvf_pkg::CNT_TEST: begin
                if (w_over) begin
                    n_result = r_lvl;
                end else if (r_h == 15'd1) begin
                    n_result = r_levels;
                end else begin
                    n_used = w_total_used[dvf_pkg::BLOCK_W-1:0];
                    n_w    = (r_w[14:1] != '0) ? {1'b0, r_w[14:1]} : 15'd1;
                    n_h    = (r_h[14:1] != '0) ? {1'b0, r_h[14:1]} : 15'd1;
                    n_lvl  = r_lvl + 4'd1;
                end
            end
            default: ;
        endcase
    end

    // Status outputs.
    always_comb begin
        o_status.busy        = (r_state != dvf_pkg::CNT_IDLE);
        o_status.good_levels = r_result;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= dvf_pkg::CNT_IDLE;
            r_result <= '0;
        end else begin
            r_state  <= n_state;
            r_result <= n_result;
        end
    end

    always_ff @(posedge i_clk) begin
        r_w      <= n_w;
        r_h      <= n_h;
        r_used   <= n_used;
        r_blocks <= n_blocks;
        r_lvl    <= n_lvl;
        r_levels <= n_levels;
    end

endmodule

FILE: design/dvf_front.sv
// ============================================================================
// DXTC vertical flip remapper - front end
// Accepts input beats, classifies each block against the current mip level
// and keeps the stream, level, row and column counters.
// ============================================================================
module dvf_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_restart,
    input  logic [dvf_pkg::DIM_W-1:0]   i_start_width,
    input  logic [dvf_pkg::DIM_W-1:0]   i_start_height,
    input  logic [1:0]                  i_block_format,
    input  dvf_pkg::t_count_status      i_status,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  dvf_pkg::t_in_item           i_in_data,
    input  logic                        i_q_ready,
    output logic                        o_push,
    output dvf_pkg::t_work              o_work
);

    logic [dvf_pkg::BLOCK_W-1:0] r_pos, n_pos, r_base, n_base;
    logic [dvf_pkg::LEVEL_W-1:0] r_level, n_level;
    logic [dvf_pkg::DIM_W-1:0]   r_mw, n_mw, r_mh, n_mh;
    logic [dvf_pkg::POS_W-1:0]   r_col, n_col, r_row, n_row;

    logic        w_changed;
    logic [15:0] w_wsum, w_hsum;
    logic [13:0] w_bpr, w_bpc, w_col_inc, w_row_inc, w_row_rev;
    logic [dvf_pkg::BLOCK_W-1:0] w_pos_inc;
    dvf_pkg::t_flip_mode w_mode;

    assign w_changed = r_level < i_status.good_levels;
    assign w_wsum    = {1'b0, r_mw} + 16'd3;
    assign w_hsum    = {1'b0, r_mh} + 16'd3;
    assign w_bpr     = w_wsum[15:2];
    assign w_bpc     = w_hsum[15:2];
    assign w_col_inc = {2'b0, r_col} + 14'd1;
    assign w_row_inc = {2'b0, r_row} + 14'd1;
    assign w_row_rev = w_bpc - 14'd1 - {2'b0, r_row};
    assign w_pos_inc = r_pos + 25'd1;

    // Hold off input while the level count is being worked out, during a restart, or while the queue is full.
    assign o_in_ready = !i_status.busy && !i_restart && i_q_ready;
    assign o_push     = i_in_valid && o_in_ready;

    // Classify the block.
    always_comb begin
        if (!w_changed) begin
            w_mode = dvf_pkg::MODE_PASS;
        end else if (r_mh == 15'd2) begin
            w_mode = dvf_pkg::MODE_HALF;
        end else if (r_mh > 15'd2) begin
            w_mode = dvf_pkg::MODE_FULL;
        end else begin
            w_mode = dvf_pkg::MODE_PASS;
        end
    end

    always_comb begin
        o_work.mode           = w_mode;
        o_work.fmt            = i_block_format;
        o_work.lo             = i_in_data.block_low;
        o_work.hi             = (i_block_format == dvf_pkg::FMT_DXT1) ? 64'd0
                                                                      : i_in_data.block_high;
        o_work.changed        = w_changed;
        o_work.good_levels    = i_status.good_levels;
        o_work.stream_pos     = r_pos;
        o_work.level_base     = r_base;
        o_work.row_rev        = w_row_rev[dvf_pkg::POS_W-1:0];
        o_work.blocks_per_row = w_bpr[dvf_pkg::POS_W:0];
        o_work.column         = r_col;
    end

    // Position counters. A level starts where the stream stood when it began.
    always_comb begin
        n_pos   = r_pos;
        n_base  = r_base;
        n_level = r_level;
        n_mw    = r_mw;
        n_mh    = r_mh;
        n_col   = r_col;
        n_row   = r_row;
        if (i_restart) begin
            n_pos   = '0;
            n_base  = '0;
            n_level = '0;
            n_mw    = i_start_width;
            n_mh    = i_start_height;
            n_col   = '0;
            n_row   = '0;
        end else if (o_push) begin
            n_pos = w_pos_inc;
            if (w_changed) begin
                n_col = w_col_inc[dvf_pkg::POS_W-1:0];
                if (w_col_inc >= w_bpr) begin
                    n_col = '0;
                    n_row = w_row_inc[dvf_pkg::POS_W-1:0];
                    if (w_row_inc >= w_bpc) begin
                        n_row   = '0;
                        n_base  = w_pos_inc;
                        n_level = r_level + 4'd1;
                        n_mw    = (r_mw[14:1] != '0) ? {1'b0, r_mw[14:1]} : 15'd1;
                        n_mh    = (r_mh[14:1] != '0) ? {1'b0, r_mh[14:1]} : 15'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_base  <= '0;
            r_level <= '0;
            r_mw    <= '0;
            r_mh    <= '0;
            r_col   <= '0;
            r_row   <= '0;
        end else begin
            r_pos   <= n_pos;
            r_base  <= n_base;
            r_level <= n_level;
            r_mw    <= n_mw;
            r_mh    <= n_mh;
            r_col   <= n_col;
            r_row   <= n_row;
        end
    end

endmodule

FILE: design/dvf_queue.sv
// ============================================================================
// DXTC vertical flip remapper - work queue
// Short first-in first-out queue of classified blocks between the front
// and back ends.
// ============================================================================
module dvf_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  dvf_pkg::t_work i_data,
    output logic           o_ready,
    output logic           o_valid,
    input  logic           i_pop,
    output dvf_pkg::t_work o_data
);

    localparam int unsigned PTR_W = (dvf_pkg::QUEUE_DEPTH > 1) ? $clog2(dvf_pkg::QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(dvf_pkg::QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH = CNT_W'(dvf_pkg::QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST  = PTR_W'(dvf_pkg::QUEUE_DEPTH - 1);

    dvf_pkg::t_work r_mem [dvf_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr, r_rd, n_rd;
    logic [CNT_W-1:0] r_count, n_count;
    logic w_push, w_pop;

    assign o_ready = (r_count != DEPTH);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];
    assign w_push  = i_push && o_ready;
    assign w_pop   = i_pop && o_valid;

    // Pointer and fill bookkeeping.
    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (w_push) begin
            n_wr = (r_wr == LAST) ? '0 : r_wr + PTR_W'(1);
        end
        if (w_pop) begin
            n_rd = (r_rd == LAST) ? '0 : r_rd + PTR_W'(1);
        end
        if (w_push && !w_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_pop && !w_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

FILE: design/dvf_back.sv
// ============================================================================
// DXTC vertical flip remapper - back end
// Two-stage pipeline: permutes the block and forms the row offset product,
// then adds up the destination index into the output register.
// ============================================================================
module dvf_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  dvf_pkg::t_work      i_q_data,
    output logic                o_q_pop,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output dvf_pkg::t_out_item  o_out_data
);

    logic                        r_s1_valid;
    dvf_pkg::t_block_pair        r_s1_blk;
    logic [dvf_pkg::BLOCK_W-1:0] r_s1_prod, r_s1_base_col, r_s1_pos;
    logic                        r_s1_full, r_s1_changed;
    logic [dvf_pkg::LEVEL_W-1:0] r_s1_good;

    logic                        r_out_valid;
    dvf_pkg::t_out_item          r_out;

    logic w_s1_ready, w_s2_ready;
    logic [dvf_pkg::BLOCK_W-1:0] w_dest;

    assign w_s2_ready = !r_out_valid || i_out_ready;
    assign w_s1_ready = !r_s1_valid || w_s2_ready;
    assign o_q_pop    = i_q_valid && w_s1_ready;

    // Stage 1: permutation and reversed-row product.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_s1_ready) begin
            r_s1_valid <= i_q_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_s1_blk      <= dvf_pkg::flip_block(i_q_data.mode, i_q_data.fmt,
                                                 i_q_data.lo, i_q_data.hi);
            r_s1_prod     <= i_q_data.row_rev * i_q_data.blocks_per_row;
            r_s1_base_col <= i_q_data.level_base
                           + {{(dvf_pkg::BLOCK_W-dvf_pkg::POS_W){1'b0}}, i_q_data.column};
            r_s1_pos      <= i_q_data.stream_pos;
            r_s1_full     <= (i_q_data.mode == dvf_pkg::MODE_FULL);
            r_s1_changed  <= i_q_data.changed;
            r_s1_good     <= i_q_data.good_levels;
        end
    end

    // Stage 2: destination index; full flips reverse the block rows.
    assign w_dest = r_s1_full ? (r_s1_base_col + r_s1_prod) : r_s1_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s2_ready) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid && w_s2_ready) begin
            r_out.flipped_low  <= r_s1_blk.lo;
            r_out.flipped_high <= r_s1_blk.hi;
            r_out.dest_index   <= w_dest;
            r_out.was_changed  <= r_s1_changed;
            r_out.good_levels  <= r_s1_good;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

FILE: design/dxtc_vertical_flip_remapper_core.sv
// ============================================================================
// DXTC vertical flip remapper - top level
// Holds the configuration registers and ties the level counter, front end,
// work queue and back end together.
// ============================================================================
// An accepted block passes through the queue, the permute stage and the output
// register, in that order. Throughput: one block per cycle while the output is
// ready and no good level count is being walked, set by the single-pass
// back-end pipeline. After a write to a known configuration index the input is
// held off while the good level count is walked.
// Reset: format unsupported, all dimensions and counts zero, stream restarted.
module dxtc_vertical_flip_remapper_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [dvf_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [dvf_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  dvf_pkg::t_in_item               i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output dvf_pkg::t_out_item              o_out_data
);

    logic [1:0]                  r_block_format, n_block_format;
    logic [dvf_pkg::DIM_W-1:0]   r_image_width, n_image_width;
    logic [dvf_pkg::DIM_W-1:0]   r_image_height, n_image_height;
    logic [dvf_pkg::LEVEL_W-1:0] r_level_count, n_level_count;
    logic [dvf_pkg::BLOCK_W-1:0] r_total_blocks, n_total_blocks;
    logic                        w_cfg_fire, w_restart;

    dvf_pkg::t_count_status w_status;
    dvf_pkg::t_work         w_push_work, w_q_work;
    logic                   w_push, w_q_ready, w_q_valid, w_q_pop;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_fire  = i_cfg_valid && o_cfg_ready;

    // Register writes; a known index restarts the stream.
    always_comb begin
        n_block_format = r_block_format;
        n_image_width  = r_image_width;
        n_image_height = r_image_height;
        n_level_count  = r_level_count;
        n_total_blocks = r_total_blocks;
        w_restart      = 1'b0;
        if (w_cfg_fire) begin
            w_restart = 1'b1;
            case (i_cfg_index)
                dvf_pkg::REG_BLOCK_FORMAT: n_block_format = i_cfg_data[1:0];
                dvf_pkg::REG_IMAGE_WIDTH:  n_image_width  = i_cfg_data[dvf_pkg::DIM_W-1:0];
                dvf_pkg::REG_IMAGE_HEIGHT: n_image_height = i_cfg_data[dvf_pkg::DIM_W-1:0];
                dvf_pkg::REG_LEVEL_COUNT:  n_level_count  = i_cfg_data[dvf_pkg::LEVEL_W-1:0];
                dvf_pkg::REG_TOTAL_BLOCKS: n_total_blocks = i_cfg_data[dvf_pkg::BLOCK_W-1:0];
                default: w_restart = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_format <= dvf_pkg::FMT_NONE;
            r_image_width  <= '0;
            r_image_height <= '0;
            r_level_count  <= '0;
            r_total_blocks <= '0;
        end else begin
            r_block_format <= n_block_format;
            r_image_width  <= n_image_width;
            r_image_height <= n_image_height;
            r_level_count  <= n_level_count;
            r_total_blocks <= n_total_blocks;
        end
    end

    dvf_level_counter u_counter (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (w_restart),
        .i_block_format (r_block_format),
        .i_image_width  (r_image_width),
        .i_image_height (r_image_height),
        .i_level_count  (r_level_count),
        .i_total_blocks (r_total_blocks),
        .o_status       (w_status)
    );

    dvf_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_restart      (w_restart),
        .i_start_width  (n_image_width),
        .i_start_height (n_image_height),
        .i_block_format (r_block_format),
        .i_status       (w_status),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_in_data      (i_in_data),
        .i_q_ready      (w_q_ready),
        .o_push         (w_push),
        .o_work         (w_push_work)
    );

    dvf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_work),
        .o_ready (w_q_ready),
        .o_valid (w_q_valid),
        .i_pop   (w_q_pop),
        .o_data  (w_q_work)
    );

    dvf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_q_data    (w_q_work),
        .o_q_pop     (w_q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
